/* rtl/core/afr_pkg.sv */
// Shared types and codes of the alpha fade ramp.
package afr_pkg;

    localparam int FIELD_W = 16;
    localparam int ALPHA_W = 8;
    localparam int MODE_W  = 2;
    localparam int DIR_W   = 2;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [DIR_W-1:0] DIR_IN  = 2'b01;
    localparam logic [DIR_W-1:0] DIR_OUT = 2'b11;

    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_IN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OUT  = 2'd2;

    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;
    localparam logic [ALPHA_W-1:0] ALPHA_MIN = 8'd0;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* rtl/core/afr_div.sv */
// Restoring serial divider, one quotient bit per cycle.
module afr_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_W-1:0]     dividend,
    input  logic [DEN_W-1:0]     divisor,
    output logic [NUM_W-1:0]     quotient,
    output afr_pkg::div_status_t status
);
    import afr_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] work_reg, work_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             qbit;

    always_comb
    begin
        trial     = {rem_reg, work_reg[NUM_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        qbit      = (trial >= {1'b0, den_reg});
        work_next = work_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one quotient bit, keep the partial remainder
            work_next = {work_reg[NUM_W-2:0], qbit};
            rem_next  = qbit ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign quotient    = work_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* rtl/core/alpha_fade_ramp.sv */
// Top level of the linear alpha fade engine: sequencer, fade state and output register.
// A start beat (command 1) begins a fade in (direction 1) or out (direction -1) over
// fade_duration ticks, presetting the elapsed time so the ramp resumes from the present
// alpha; a tick beat (command 0) advances an active fade by delta_ticks. Every input beat
// yields exactly one output beat carrying the alpha and fade_state after that beat. Time
// fields are used in their low TIME_BITS bits. Snaps, finished fades, idle ticks and
// no-effect starts go from the prepare step straight to the done step; a beat that needs
// a new elapsed time or alpha also passes the multiply step and the shared serial divider,
// which retires one quotient bit of a (TIME_BITS+8)-bit dividend per cycle, before the
// quotient is picked up. in_stall stays high while a beat is in work; the output register
// lets the next beat enter while a result waits on out_stall.
module alpha_fade_ramp #(
    parameter int TIME_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [1:0]  direction,
    input  logic [15:0] fade_duration,
    input  logic [15:0] delta_ticks,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  alpha,
    output logic [1:0]  fade_state
);
    import afr_pkg::*;

    localparam int TB    = TIME_BITS;
    localparam int NUM_W = TB + ALPHA_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [ALPHA_W-1:0] alpha_reg, alpha_next;
    logic [TB-1:0]      total_reg, total_next;
    logic [TB:0]        elapsed_reg, elapsed_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;

    logic               cmd_reg, cmd_next;
    logic [DIR_W-1:0]   dir_reg, dir_next;
    logic [TB-1:0]      tval_reg, tval_next;
    logic [TB:0]        esum_reg, esum_next;
    logic [ALPHA_W-1:0] mul_a_reg, mul_a_next;
    logic [TB-1:0]      mul_b_reg, mul_b_next;
    logic [TB-1:0]      den_reg, den_next;

    logic               out_valid_reg, out_valid_next;
    logic [ALPHA_W-1:0] out_alpha_reg;
    logic [MODE_W-1:0]  out_mode_reg;

    logic [TB+FIELD_W-1:0] dur_wide;
    logic [TB+FIELD_W-1:0] delta_wide;
    logic [TB-1:0]         dur_t;
    logic [TB-1:0]         delta_t;
    logic                  in_fire;
    logic                  out_free;
    logic                  done_ge;
    logic [TB-1:0]         remain;
    logic                  div_start;
    logic [NUM_W-1:0]      product;
    logic [NUM_W-1:0]      quotient;
    div_status_t           div_stat;

    // take the low TIME_BITS bits of each time field, zero-extended when wider
    assign dur_wide   = {{TB{1'b0}}, fade_duration};
    assign delta_wide = {{TB{1'b0}}, delta_ticks};
    assign dur_t      = dur_wide[TB-1:0];
    assign delta_t    = delta_wide[TB-1:0];

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign done_ge   = (esum_reg >= {1'b0, total_reg});
    assign remain    = total_reg - esum_reg[TB-1:0];
    assign product   = NUM_W'(mul_a_reg) * NUM_W'(mul_b_reg);
    assign div_start = (state_reg == ST_MUL);

    afr_div #(
        .NUM_W (NUM_W),
        .DEN_W (TB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (den_reg),
        .quotient (quotient),
        .status   (div_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        alpha_next     = alpha_reg;
        total_next     = total_reg;
        elapsed_next   = elapsed_reg;
        mode_next      = mode_reg;
        cmd_next       = cmd_reg;
        dir_next       = dir_reg;
        tval_next      = tval_reg;
        esum_next      = esum_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        den_next       = den_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    // hold the beat and the advanced elapsed time for the prepare step
                    cmd_next   = command;
                    dir_next   = direction;
                    tval_next  = dur_t;
                    esum_next  = elapsed_reg + {1'b0, delta_t};
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_DONE;
                if (cmd_reg == CMD_START)
                begin
                    if (dir_reg == DIR_IN)
                    begin
                        if (alpha_reg == ALPHA_MAX || tval_reg == '0)
                        begin
                            alpha_next   = ALPHA_MAX;
                            total_next   = '0;
                            elapsed_next = '0;
                            mode_next    = MODE_IDLE;
                        end
                        else
                        begin
                            // elapsed = alpha*T/255
                            total_next = tval_reg;
                            mode_next  = MODE_IN;
                            mul_a_next = alpha_reg;
                            mul_b_next = tval_reg;
                            den_next   = TB'(ALPHA_MAX);
                            state_next = ST_MUL;
                        end
                    end
                    else if (dir_reg == DIR_OUT)
                    begin
                        if (alpha_reg == ALPHA_MIN || tval_reg == '0)
                        begin
                            alpha_next   = ALPHA_MIN;
                            total_next   = '0;
                            elapsed_next = '0;
                            mode_next    = MODE_IDLE;
                        end
                        else
                        begin
                            // elapsed = (255-alpha)*T/255
                            total_next = tval_reg;
                            mode_next  = MODE_OUT;
                            mul_a_next = ALPHA_MAX - alpha_reg;
                            mul_b_next = tval_reg;
                            den_next   = TB'(ALPHA_MAX);
                            state_next = ST_MUL;
                        end
                    end
                end
                else if (mode_reg == MODE_IN || mode_reg == MODE_OUT)
                begin
                    if (done_ge)
                    begin
                        // fade finished: land at the end value and drop to idle
                        alpha_next   = (mode_reg == MODE_IN) ? ALPHA_MAX : ALPHA_MIN;
                        total_next   = '0;
                        elapsed_next = '0;
                        mode_next    = MODE_IDLE;
                    end
                    else
                    begin
                        elapsed_next = esum_reg;
                        mul_a_next   = ALPHA_MAX;
                        mul_b_next   = (mode_reg == MODE_IN) ? esum_reg[TB-1:0] : remain;
                        den_next     = total_reg;
                        state_next   = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    if (cmd_reg == CMD_START)
                    begin
                        elapsed_next = {1'b0, quotient[TB-1:0]};
                    end
                    else
                    begin
                        alpha_next = quotient[ALPHA_W-1:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // present the result once the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alpha_reg     <= ALPHA_MAX;
            total_reg     <= '0;
            elapsed_reg   <= '0;
            mode_reg      <= MODE_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alpha_reg     <= alpha_next;
            total_reg     <= total_next;
            elapsed_reg   <= elapsed_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        dir_reg   <= dir_next;
        tval_reg  <= tval_next;
        esum_reg  <= esum_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        den_reg   <= den_next;
        if (state_reg == ST_DONE && out_free)
        begin
            out_alpha_reg <= alpha_reg;
            out_mode_reg  <= mode_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign alpha      = out_alpha_reg;
    assign fade_state = out_mode_reg;

endmodule

/* rtl/core/afr_checker.sv */
// Port-level checks of the alpha fade ramp and their binding to the top level.
module afr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        command,
    input logic [1:0]  direction,
    input logic [15:0] fade_duration,
    input logic [15:0] delta_ticks,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  alpha,
    input logic [1:0]  fade_state
);
    import afr_pkg::*;

    // a result beat held by the sink keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(alpha) && $stable(fade_state))
        else $error("output beat changed while stalled");

    // an input beat held off by the engine keeps its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(command) && $stable(direction)
            && $stable(fade_duration) && $stable(delta_ticks))
        else $error("input beat changed while stalled");

    // an accepted input beat busies the engine in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice in a row");

    // the engine only rests at a fully opaque or fully clear alpha
    a_idle_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fade_state == MODE_IDLE |-> alpha == ALPHA_MAX || alpha == ALPHA_MIN)
        else $error("idle with alpha between ends");

    // a fade in never reports full alpha before it finishes
    a_fade_in_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fade_state == MODE_IN |-> alpha != ALPHA_MAX)
        else $error("fading in at full alpha");

endmodule

bind alpha_fade_ramp afr_checker u_afr_checker (.*);
